@@ rtl/crt_pkg.sv @@
// Package for the confirmable retransmit table.
// Holds the slot record, the item and event codes and the controller states.
// No dependencies; used by every module in rtl/.
package crt_pkg;

  localparam int unsigned TableDepthDef = 8;
  localparam int unsigned IdW    = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ToutW  = 16;
  localparam int unsigned SendsW = 4;
  localparam logic [SendsW-1:0] MaxSendsRst = 4'd4;

  typedef enum logic [1:0] {
    KindSent  = 2'd0,
    KindAck   = 2'd1,
    KindTick  = 2'd2,
    KindClear = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EvRetransmit = 2'd0,
    EvGivenUp    = 2'd1,
    EvFull       = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  // interval is deadline minus last time, kept instead of the last time
  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    logic [TimeW-1:0]  deadline;
    logic [TimeW-1:0]  interval;
    logic [SendsW-1:0] sends;
  } slot_t;

  // one head-cell decision handed back to the controller
  typedef struct packed {
    logic           res_valid;
    event_e         ev;
    logic [IdW-1:0] id;
    logic           wrote;
  } head_res_t;

endpackage

@@ rtl/crt_cell.sv @@
// One slot cell of the rotating table chain.
// Loads its neighbor's slot while the chain shifts; depends on crt_pkg.
module crt_cell
  import crt_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           clr_i,
  input  logic [IdW-1:0] key_i,
  input  slot_t          d_i,
  output slot_t          q_o,
  output logic           match_o
);

  logic  valid_q;
  slot_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= d_i;
    end
  end

  always_comb begin
    q_o       = data_q;
    q_o.valid = valid_q;
  end

  assign match_o = valid_q && (data_q.id == key_i);

endmodule

@@ rtl/crt_head.sv @@
// Update logic for the slot at the head of the chain.
// Applies one sent, ack or tick step to that slot; depends on crt_pkg.
module crt_head
  import crt_pkg::*;
(
  input  kind_e             kind_i,
  input  logic [IdW-1:0]    msg_id_i,
  input  logic [TimeW-1:0]  now_i,
  input  logic [ToutW-1:0]  first_timeout_i,
  input  logic [SendsW-1:0] max_sends_i,
  input  logic              any_match_i,
  input  logic              wrote_i,
  input  slot_t             slot_i,
  output slot_t             slot_o,
  output head_res_t         res_o
);

  logic [TimeW-1:0] diff;
  logic             overdue;
  logic             hit;

  assign diff    = now_i - slot_i.deadline;
  assign overdue = (diff != '0) && !diff[TimeW-1];
  assign hit     = slot_i.valid && (slot_i.id == msg_id_i);

  always_comb begin
    slot_o          = slot_i;
    res_o.res_valid = 1'b0;
    res_o.ev        = EvRetransmit;
    res_o.id        = slot_i.id;
    res_o.wrote     = wrote_i;
    unique case (kind_i)
      KindSent: begin
        // restart a pending ID, else take the lowest free slot once
        if (any_match_i ? hit : (!slot_i.valid && !wrote_i)) begin
          slot_o.valid    = 1'b1;
          slot_o.id       = msg_id_i;
          slot_o.deadline = now_i + TimeW'(first_timeout_i);
          slot_o.interval = TimeW'(first_timeout_i);
          slot_o.sends    = '0;
          res_o.wrote     = 1'b1;
        end
      end
      KindAck: begin
        if (hit) begin
          slot_o.valid = 1'b0;
        end
      end
      KindTick: begin
        if (slot_i.valid) begin
          if (slot_i.sends >= max_sends_i) begin
            slot_o.valid    = 1'b0;
            res_o.res_valid = 1'b1;
            res_o.ev        = EvGivenUp;
          end else if (overdue) begin
            res_o.res_valid = 1'b1;
            slot_o.sends    = slot_i.sends + SendsW'(1);
            slot_o.deadline = slot_i.deadline + {slot_i.interval[TimeW-2:0], 1'b0};
            slot_o.interval = {slot_i.interval[TimeW-2:0], 1'b0};
          end
        end
      end
      default: begin
        // clear is handled in the cells directly
      end
    endcase
  end

endmodule

@@ rtl/confirmable_retransmit_table.sv @@
// Top level of the confirmable retransmit table: controller and slot chain.
// Instantiates crt_cell and crt_head; depends on crt_pkg.
//
//   channel   signals                                      handshake
//   input     kind_i msg_id_i now_i first_timeout_i        start && !busy
//   config    cfg_data_i                                   cfg_valid_i && cfg_ready_o
//   result    event_res_o msg_id_res_o last_o              res_valid_o, one cycle
//
// Sent, ack and tick items rotate the slot chain once, through the scan and
// flush states, before the next accept; the one head cell sees one slot a
// cycle. Clear items and table-full sent items leave the controller idle.
// Each result is held until the head finds the next one or the scan ends, so
// the final one carries last; it is registered from the flush state.
// Reset empties the table and sets max_sends to 4; there is no clearing pass.
module confirmable_retransmit_table
  import crt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [IdW-1:0]    msg_id_i,
  input  logic [TimeW-1:0]  now_i,
  input  logic [ToutW-1:0]  first_timeout_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SendsW-1:0] cfg_data_i,
  output logic              res_valid_o,
  output logic [1:0]        event_res_o,
  output logic [IdW-1:0]    msg_id_res_o,
  output logic              last_o
);

  localparam int unsigned CntW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SendsW-1:0] max_sends_q;

  kind_e             kind_q;
  logic [IdW-1:0]    msg_id_q;
  logic [TimeW-1:0]  now_q;
  logic [ToutW-1:0]  timeout_q;
  logic              any_match_q, any_match_d;
  logic              wrote_q, wrote_d;

  logic              pend_v_q, pend_v_d;
  event_e            pend_ev_q, pend_ev_d;
  logic [IdW-1:0]    pend_id_q, pend_id_d;

  logic              res_v_q, res_v_d;
  event_e            res_ev_q, res_ev_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic              res_last_q, res_last_d;

  slot_t                  cell_q [TABLE_DEPTH];
  slot_t                  head_new;
  head_res_t              head_res;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic                   accept;
  logic                   shift;
  logic                   clr;

  assign accept = start && !busy;
  assign shift  = (state_q == StScan);
  assign clr    = accept && (kind_e'(kind_i) == KindClear);

  // Slot chain: the head is updated and re-enters at the tail
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    slot_t nxt;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nxt = head_new;
    end else begin : g_mid
      assign nxt = cell_q[i+1];
    end
    crt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .clr_i   (clr),
      .key_i   (msg_id_i),
      .d_i     (nxt),
      .q_o     (cell_q[i]),
      .match_o (match_vec[i])
    );
    assign valid_vec[i] = cell_q[i].valid;
  end

  crt_head u_head (
    .kind_i          (kind_q),
    .msg_id_i        (msg_id_q),
    .now_i           (now_q),
    .first_timeout_i (timeout_q),
    .max_sends_i     (max_sends_q),
    .any_match_i     (any_match_q),
    .wrote_i         (wrote_q),
    .slot_i          (cell_q[0]),
    .slot_o          (head_new),
    .res_o           (head_res)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sends_q <= MaxSendsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_sends_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      wrote_q  <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      wrote_q  <= wrote_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_e'(kind_i);
      msg_id_q  <= msg_id_i;
      now_q     <= now_i;
      timeout_q <= first_timeout_i;
    end
    any_match_q <= any_match_d;
    pend_ev_q   <= pend_ev_d;
    pend_id_q   <= pend_id_d;
    res_ev_q    <= res_ev_d;
    res_id_q    <= res_id_d;
    res_last_q  <= res_last_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wrote_d     = wrote_q;
    any_match_d = any_match_q;
    pend_v_d    = pend_v_q;
    pend_ev_d   = pend_ev_q;
    pend_id_d   = pend_id_q;
    res_v_d     = 1'b0;
    res_ev_d    = res_ev_q;
    res_id_d    = res_id_q;
    res_last_d  = res_last_q;
    busy        = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          any_match_d = |match_vec;
          wrote_d     = 1'b0;
          cnt_d       = '0;
          unique case (kind_e'(kind_i)) inside
            KindSent: begin
              if (!(|match_vec) && (&valid_vec)) begin
                res_v_d    = 1'b1;
                res_ev_d   = EvFull;
                res_id_d   = msg_id_i;
                res_last_d = 1'b1;
              end else begin
                state_d = StScan;
              end
            end
            KindAck, KindTick: begin
              state_d = StScan;
            end
            default: begin
              // clear: cells drop their valid bits this edge
            end
          endcase
        end
      end
      StScan: begin
        wrote_d = head_res.wrote;
        // a new result pushes the held one out, which then cannot be last
        if (head_res.res_valid) begin
          if (pend_v_q) begin
            res_v_d    = 1'b1;
            res_ev_d   = pend_ev_q;
            res_id_d   = pend_id_q;
            res_last_d = 1'b0;
          end
          pend_v_d  = 1'b1;
          pend_ev_d = head_res.ev;
          pend_id_d = head_res.id;
        end
        if (cnt_q == CntW'(TABLE_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = StFlush;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      StFlush: begin
        if (pend_v_q) begin
          res_v_d    = 1'b1;
          res_ev_d   = pend_ev_q;
          res_id_d   = pend_id_q;
          res_last_d = 1'b1;
        end
        pend_v_d = 1'b0;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign res_valid_o  = res_v_q;
  assign event_res_o  = res_ev_q;
  assign msg_id_res_o = res_id_q;
  assign last_o       = res_last_q;

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (valid_vec == '0))
    else $error("table not empty after clear item");

  a_flush_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |=> (state_q == StIdle) && !pend_v_q)
    else $error("flush did not return to idle");

  a_no_last_mid_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) && res_valid_o |-> !last_o)
    else $error("last flag raised during scan");

  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (cnt_q == '0) && !pend_v_q)
    else $error("slot counter or held result left over in idle");
`endif

endmodule
